### sv/hrsa_pkg.sv
package hrsa_pkg;

   // item operation codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // phase codes
   localparam logic [1:0] PHASE_SMALL  = 2'd0;
   localparam logic [1:0] PHASE_MEDIUM = 2'd1;
   localparam logic [1:0] PHASE_LARGE  = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INTERVAL    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_STEP         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIUM_STEP        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE_STEP         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_PHASE_COUNT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIUM_PHASE_COUNT = 3'd5;

   localparam int CSR_DATA_W = 16;
   localparam logic [15:0] VALUE_MAX = 16'hFFFF;
   localparam logic [3:0]  GRID_FIVE = 4'd5;
   localparam logic [3:0]  GRID_TEN  = 4'd10;

   typedef struct packed {
      logic [15:0] repeat_interval;
      logic [15:0] small_step;
      logic [15:0] medium_step;
      logic [15:0] large_step;
      logic [7:0]  small_phase_count;
      logic [7:0]  medium_phase_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        direction_up;
      logic [15:0] start_value;
      logic [31:0] now;
   } item_type;

   typedef struct packed {
      logic [15:0] value;
      logic        stepped;
      logic        active;
      logic [1:0]  phase;
   } result_type;

   // 16 = 1 mod 5, so nibble sums keep the residue
   function automatic logic [3:0] mod5_f(input logic [15:0] v);
      logic [5:0] s1;
      logic [4:0] s2;
      logic [4:0] r;
      s1 = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
      s2 = 5'(s1[3:0]) + 5'(s1[5:4]);
      if (s2 >= 5'd15) begin
         r = s2 - 5'd15;
      end else if (s2 >= 5'd10) begin
         r = s2 - 5'd10;
      end else if (s2 >= 5'd5) begin
         r = s2 - 5'd5;
      end else begin
         r = s2;
      end
      return r[3:0];
   endfunction

   // residue mod 10 from residue mod 5 and parity
   function automatic logic [3:0] mod10_f(input logic [15:0] v);
      logic [3:0] r5;
      r5 = mod5_f(v);
      if (r5[0] == v[0]) begin
         return r5;
      end
      return r5 + 4'd5;
   endfunction

endpackage

### sv/hrsa_cfg_regs.sv
module hrsa_cfg_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [hrsa_pkg::CSR_INDEX_W-1:0]     wr_index,
   input  logic [hrsa_pkg::CSR_DATA_W-1:0]      wr_data,
   output hrsa_pkg::cfg_type                    cfg
);
   import hrsa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_REPEAT_INTERVAL:    cfg_in.repeat_interval    = wr_data;
            CSR_SMALL_STEP:         cfg_in.small_step         = wr_data;
            CSR_MEDIUM_STEP:        cfg_in.medium_step        = wr_data;
            CSR_LARGE_STEP:         cfg_in.large_step         = wr_data;
            CSR_SMALL_PHASE_COUNT:  cfg_in.small_phase_count  = wr_data[7:0];
            CSR_MEDIUM_PHASE_COUNT: cfg_in.medium_phase_count = wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_interval    <= 16'd100;
         cfg_ff.small_step         <= 16'd1;
         cfg_ff.medium_step        <= 16'd5;
         cfg_ff.large_step         <= 16'd10;
         cfg_ff.small_phase_count  <= 8'd10;
         cfg_ff.medium_phase_count <= 8'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/hrsa_step_core.sv
module hrsa_step_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  hrsa_pkg::item_type    item,
   input  hrsa_pkg::cfg_type     cfg,
   output hrsa_pkg::result_type  result
);
   import hrsa_pkg::*;

   logic        held_ff,      held_in;
   logic        going_up_ff,  going_up_in;
   logic [1:0]  phase_ff,     phase_in;
   logic [7:0]  count_ff,     count_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [15:0] value_ff,     value_in;

   logic        is_start;
   logic        dir;
   logic [15:0] base;
   logic [1:0]  ph;
   logic [7:0]  cnt;
   logic [15:0] step;
   logic [7:0]  limit;
   logic [16:0] sum;
   logic [15:0] moved;
   logic [7:0]  cnt_inc;
   logic [3:0]  rem;
   logic [3:0]  grid;
   logic [16:0] up_round;
   logic [15:0] rounded;
   logic [15:0] step_value;
   logic [1:0]  step_phase;
   logic [7:0]  step_count;
   logic [31:0] elapsed;
   logic        tick_go;
   logic        stepped;

   // one step from the selected starting point
   always_comb begin
      is_start = (item.op == OP_START);
      dir  = is_start ? item.direction_up : going_up_ff;
      base = is_start ? item.start_value  : value_ff;
      ph   = is_start ? PHASE_SMALL       : phase_ff;
      cnt  = is_start ? 8'd0              : count_ff;

      case (ph)
         PHASE_SMALL: begin
            step  = cfg.small_step;
            limit = cfg.small_phase_count;
            grid  = GRID_FIVE;
         end
         PHASE_MEDIUM: begin
            step  = cfg.medium_step;
            limit = cfg.medium_phase_count;
            grid  = GRID_TEN;
         end
         default: begin
            step  = cfg.large_step;
            limit = 8'd0;
            grid  = GRID_TEN;
         end
      endcase

      sum = {1'b0, base} + {1'b0, step};
      if (dir) begin
         moved = sum[16] ? VALUE_MAX : sum[15:0];
      end else begin
         moved = (base > step) ? (base - step) : 16'd0;
      end

      rem      = (ph == PHASE_SMALL) ? mod5_f(moved) : mod10_f(moved);
      up_round = {1'b0, moved} - 17'(rem) + 17'(grid);
      if (rem == 4'd0) begin
         rounded = moved;
      end else if (dir) begin
         rounded = up_round[16] ? VALUE_MAX : up_round[15:0];
      end else begin
         rounded = moved - 16'(rem);
      end

      cnt_inc    = cnt + 8'd1;
      step_value = moved;
      step_phase = ph;
      step_count = cnt;
      if (limit != 8'd0) begin
         if (cnt_inc >= limit) begin
            step_value = rounded;
            step_phase = (ph == PHASE_SMALL) ? PHASE_MEDIUM : PHASE_LARGE;
            step_count = 8'd0;
         end else begin
            step_count = cnt_inc;
         end
      end
   end

   // state update per operation
   always_comb begin
      elapsed      = item.now - last_time_ff;
      tick_go      = held_ff && (elapsed >= {16'd0, cfg.repeat_interval});
      held_in      = held_ff;
      going_up_in  = going_up_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      last_time_in = last_time_ff;
      value_in     = value_ff;
      stepped      = 1'b0;
      case (item.op)
         OP_START: begin
            held_in      = 1'b1;
            going_up_in  = item.direction_up;
            last_time_in = item.now;
            value_in     = step_value;
            phase_in     = step_phase;
            count_in     = step_count;
            stepped      = 1'b1;
         end
         OP_STOP: begin
            held_in  = 1'b0;
            phase_in = PHASE_SMALL;
            count_in = 8'd0;
         end
         OP_TICK: begin
            if (tick_go) begin
               last_time_in = item.now;
               value_in     = step_value;
               phase_in     = step_phase;
               count_in     = step_count;
               stepped      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         going_up_ff  <= 1'b0;
         phase_ff     <= PHASE_SMALL;
         count_ff     <= 8'd0;
         last_time_ff <= 32'd0;
         value_ff     <= 16'd0;
      end else if (advance) begin
         held_ff      <= held_in;
         going_up_ff  <= going_up_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         value_ff     <= value_in;
      end
   end

   assign result.value   = value_in;
   assign result.stepped = stepped;
   assign result.active  = held_in;
   assign result.phase   = phase_in;

endmodule

### sv/hold_repeat_step_accelerator.sv
// hold-to-repeat value adjuster with step acceleration
// req channel: one transfer per item (op start / stop / tick, direction,
//   start value, timestamp); every item yields exactly one rsp transfer
// rsp channel: adjusted value, stepped flag, hold active flag, phase
// csr channel: register index and write data, always ready, write only
//   while no item is in flight
// path: an accepted item is loaded into the input register, and its result
//   goes into the output register once that one is free, raising rsp_valid
// throughput: one item per cycle while rsp_ready stays high; the state update
//   (elapsed compare, step add with clamp, grid rounding) is one combinational
//   pass between the input register and the output register
// receiver stall: the output register holds its result, the input
//   register keeps one more item, then req_ready drops
// reset: clears both valid flags, the hold state, value and phase; the
//   configuration registers return to their default values
module hold_repeat_step_accelerator (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic                                req_direction_up,
   input  logic [15:0]                         req_start_value,
   input  logic [31:0]                         req_now,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_value,
   output logic                                rsp_stepped,
   output logic                                rsp_active,
   output logic [1:0]                          rsp_phase,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hrsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hrsa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hrsa_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff,     item_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff,       rsp_in;

   cfg_type    cfg;
   logic       out_free;
   logic       advance;

   // output register frees when empty or when its transfer completes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // item moves through the step logic into the output register
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   hrsa_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   hrsa_step_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (rsp_in)
   );

   always_comb begin
      item_in.op           = req_op;
      item_in.direction_up = req_direction_up;
      item_in.start_value  = req_start_value;
      item_in.now          = req_now;
      // load a new item whenever the input register is free
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_ff.value;
   assign rsp_stepped = rsp_ff.stepped;
   assign rsp_active  = rsp_ff.active;
   assign rsp_phase   = rsp_ff.phase;

   // a step only happens while a hold is active
   a_step_needs_hold: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_stepped || rsp_active))
      else $error("step reported without an active hold");

   // a start always steps and activates the hold
   a_start_steps: assert property (
      @(posedge clock) disable iff (reset)
      (advance && item_ff.op == OP_START) |=> (rsp_valid && rsp_stepped && rsp_active))
      else $error("start item did not step");

   // a stop ends the hold and returns to the small phase
   a_stop_clears: assert property (
      @(posedge clock) disable iff (reset)
      (advance && item_ff.op == OP_STOP)
         |=> (rsp_valid && !rsp_active && !rsp_stepped && rsp_phase == PHASE_SMALL))
      else $error("stop item did not clear the hold");

endmodule

### tb/sv/hold_repeat_step_accelerator_test.sv
`timescale 1ns / 1ps

module hold_repeat_step_accelerator_test;
   import hrsa_pkg::*;

   // op code 3 has no meaning, the block only reports its state
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   // index past the last register, writes to it must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   // limit for the watchdog, far beyond the slowest run
   localparam int CYCLE_LIMIT = 400000;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side, all known from time zero
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_STOP;
   logic        req_direction_up = 1'b0;
   logic [15:0] req_start_value = 16'd0;
   logic [31:0] req_now = 32'd0;

   // response side
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_value;
   logic        rsp_stepped;
   logic        rsp_active;
   logic [1:0]  rsp_phase;

   // register write side
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_REPEAT_INTERVAL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // idling percentages, changed between test phases
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int fail_count  = 0;
   int cycle_count = 0;

   // running timestamp for generated holds
   logic [31:0] stamp = 32'd0;

   // adjuster state as the block should hold it
   cfg_type     adj_cfg;
   logic        adj_held;
   logic        adj_up;
   logic [1:0]  adj_phase;
   logic [7:0]  adj_count;
   logic [31:0] adj_last_time;
   logic [15:0] adj_value;

   // adjustments predicted for accepted items, oldest first
   result_type awaited_adjustments[$];

   hold_repeat_step_accelerator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_direction_up (req_direction_up),
      .req_start_value  (req_start_value),
      .req_now          (req_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_stepped      (rsp_stepped),
      .rsp_active       (rsp_active),
      .rsp_phase        (rsp_phase),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // one step in the current phase, with the phase-end rounding
   function automatic void apply_step();
      logic [15:0] size;
      logic [7:0]  limit;
      int unsigned grid;
      int unsigned rem;
      int unsigned rounded;
      logic [16:0] sum;
      if (adj_phase == PHASE_SMALL) begin
         size  = adj_cfg.small_step;
         limit = adj_cfg.small_phase_count;
         grid  = 32'(GRID_FIVE);
      end else if (adj_phase == PHASE_MEDIUM) begin
         size  = adj_cfg.medium_step;
         limit = adj_cfg.medium_phase_count;
         grid  = 32'(GRID_TEN);
      end else begin
         // last phase never ends
         size  = adj_cfg.large_step;
         limit = 8'd0;
         grid  = 0;
      end
      if (adj_up) begin
         sum = {1'b0, adj_value} + {1'b0, size};
         adj_value = sum[16] ? VALUE_MAX : sum[15:0];
      end else begin
         adj_value = (adj_value > size) ? adj_value - size : 16'd0;
      end
      if (limit != 8'd0) begin
         adj_count = adj_count + 8'd1;
         if (adj_count >= limit) begin
            rem = 32'(adj_value) % grid;
            if (rem != 0) begin
               if (adj_up) begin
                  // rounding up saturates like a step
                  rounded = 32'(adj_value) - rem + grid;
                  adj_value = (rounded > VALUE_MAX) ? VALUE_MAX : 16'(rounded);
               end else begin
                  adj_value = adj_value - 16'(rem);
               end
            end
            adj_phase = (adj_phase == PHASE_SMALL) ? PHASE_MEDIUM : PHASE_LARGE;
            adj_count = 8'd0;
         end
      end
   endfunction

   // next state and the result that one item yields
   function automatic result_type predict_adjustment(input item_type it);
      result_type  r;
      logic        stepped_now;
      logic [31:0] elapsed;
      stepped_now = 1'b0;
      case (it.op)
         OP_START: begin
            // also restarts a hold already in progress
            adj_held      = 1'b1;
            adj_up        = it.direction_up;
            adj_phase     = PHASE_SMALL;
            adj_count     = 8'd0;
            adj_last_time = it.now;
            adj_value     = it.start_value;
            apply_step();
            stepped_now = 1'b1;
         end
         OP_STOP: begin
            adj_held  = 1'b0;
            adj_phase = PHASE_SMALL;
            adj_count = 8'd0;
         end
         OP_TICK: begin
            // elapsed time wraps with the 32 bit counter
            elapsed = it.now - adj_last_time;
            if (adj_held && elapsed >= {16'd0, adj_cfg.repeat_interval}) begin
               apply_step();
               adj_last_time = it.now;
               stepped_now   = 1'b1;
            end
         end
         default: begin
            // unknown op leaves everything as it is
         end
      endcase
      r.value   = adj_value;
      r.stepped = stepped_now;
      r.active  = adj_held;
      r.phase   = adj_phase;
      return r;
   endfunction

   // watches all three channels: checks results, predicts items, tracks registers
   always @(posedge clock) begin : channel_monitor
      result_type want;
      item_type   got_item;
      if (!reset) begin
         // results leave before new items are predicted, an item's result
         // can never arrive at the edge where the item is accepted
         if (rsp_valid && rsp_ready) begin
            if (awaited_adjustments.size() == 0) begin
               $error("result transfer with nothing expected, value %0d", rsp_value);
               fail_count++;
            end else begin
               want = awaited_adjustments.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_stepped !== want.stepped) begin
                  $error("stepped: expected %0d, actual %0d", want.stepped, rsp_stepped);
                  fail_count++;
               end
               if (rsp_active !== want.active) begin
                  $error("active: expected %0d, actual %0d", want.active, rsp_active);
                  fail_count++;
               end
               if (rsp_phase !== want.phase) begin
                  $error("phase: expected %0d, actual %0d", want.phase, rsp_phase);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            got_item.op           = req_op;
            got_item.direction_up = req_direction_up;
            got_item.start_value  = req_start_value;
            got_item.now          = req_now;
            awaited_adjustments.push_back(predict_adjustment(got_item));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REPEAT_INTERVAL:    adj_cfg.repeat_interval    = csr_wdata;
               CSR_SMALL_STEP:         adj_cfg.small_step         = csr_wdata;
               CSR_MEDIUM_STEP:        adj_cfg.medium_step        = csr_wdata;
               CSR_LARGE_STEP:         adj_cfg.large_step         = csr_wdata;
               CSR_SMALL_PHASE_COUNT:  adj_cfg.small_phase_count  = csr_wdata[7:0];
               CSR_MEDIUM_PHASE_COUNT: adj_cfg.medium_phase_count = csr_wdata[7:0];
               default: begin
                  // spare index, ignored
               end
            endcase
         end
      end
   end

   // one request transfer; valid stays up afterwards so items can go back to back
   task automatic drive_request(input logic [1:0] op, input logic dir,
                                input logic [15:0] start, input logic [31:0] now_in);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_direction_up <= dir;
      req_start_value  <= start;
      req_now          <= now_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender goes quiet until every predicted result has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_adjustments.size() != 0) @(posedge clock);
   endtask

   // one register write transfer, valid left up for the next write
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // full register set, only called with the block drained
   task automatic apply_settings(input cfg_type c);
      write_register(CSR_SPARE_INDEX, 16'($urandom));
      write_register(CSR_REPEAT_INTERVAL, c.repeat_interval);
      write_register(CSR_SMALL_STEP, c.small_step);
      write_register(CSR_MEDIUM_STEP, c.medium_step);
      write_register(CSR_LARGE_STEP, c.large_step);
      // upper byte is don't care for the counts
      write_register(CSR_SMALL_PHASE_COUNT, {8'($urandom), c.small_phase_count});
      write_register(CSR_MEDIUM_PHASE_COUNT, {8'($urandom), c.medium_phase_count});
      csr_valid <= 1'b0;
   endtask

   // reset settings: early and exact ticks, unknown op, stop, idle tick
   task automatic test_hold_repeat();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drive_request(OP_START, 1'b1, 16'd0, 32'd1000);
      drive_request(OP_TICK, 1'b1, 16'd0, 32'd1050);        // too early
      drive_request(OP_TICK, 1'b0, 16'hFFFF, 32'd1100);     // exactly one interval
      drive_request(OP_TICK, 1'b1, 16'd0, 32'd1199);        // one tick short
      drive_request(OP_UNKNOWN, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      drive_request(OP_STOP, 1'b0, 16'd0, 32'd0);
      drive_request(OP_TICK, 1'b1, 16'd0, 32'd5000);        // not held
   endtask

   // timestamp wrap, clamp at zero, restart while held, saturation
   task automatic test_wrap_and_limits();
      drive_request(OP_START, 1'b0, 16'd3, 32'hFFFF_FFC0);
      drive_request(OP_TICK, 1'b0, 16'd0, 32'h0000_0030);   // elapsed across wrap
      drive_request(OP_TICK, 1'b0, 16'd0, 32'h0000_0094);
      drive_request(OP_TICK, 1'b0, 16'd0, 32'h0000_00F8);   // stays at zero
      drive_request(OP_START, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      drive_request(OP_TICK, 1'b1, 16'd0, 32'h0000_0063);   // saturates
      drive_request(OP_STOP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
   endtask

   // short phases: rounding to 5 then 10 in both directions
   task automatic test_phase_rounding();
      cfg_type c;
      c.repeat_interval    = 16'd0;
      c.small_step         = 16'd3;
      c.medium_step        = 16'd7;
      c.large_step         = VALUE_MAX;
      c.small_phase_count  = 8'd2;
      c.medium_phase_count = 8'd2;
      pause_until_drained();
      apply_settings(c);
      send_idle_pct = 14;
      rsp_stall_pct = 14;
      // up: 14, 17 -> 20, 27, 34 -> 40, then saturate
      drive_request(OP_START, 1'b1, 16'd11, 32'd10);
      drive_request(OP_TICK, 1'b0, 16'd0, 32'd10);
      drive_request(OP_TICK, 1'b0, 16'd0, 32'd11);
      drive_request(OP_TICK, 1'b0, 16'd0, 32'd12);
      drive_request(OP_TICK, 1'b0, 16'd0, 32'd13);
      drive_request(OP_STOP, 1'b0, 16'd0, 32'd14);
      // down: 27, 24 -> 20, 13, 6 -> 0, then clamp
      drive_request(OP_START, 1'b0, 16'd30, 32'd20);
      drive_request(OP_TICK, 1'b1, 16'd0, 32'd21);
      drive_request(OP_TICK, 1'b1, 16'd0, 32'd22);
      drive_request(OP_TICK, 1'b1, 16'd0, 32'd23);
      drive_request(OP_TICK, 1'b1, 16'd0, 32'd24);
      drive_request(OP_STOP, 1'b1, 16'd0, 32'd25);
   endtask

   // mostly whole holds (start, ticks, stop) with some random noise items
   task automatic run_hold_traffic(input int n_items);
      int          sent;
      int          n_ticks;
      int          pick;
      logic [31:0] delta;
      logic [15:0] interval;
      logic [15:0] start;
      sent = 0;
      while (sent < n_items) begin
         interval = adj_cfg.repeat_interval;
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(7) == 0) begin
               stamp = $urandom;
            end
            // start values near both ends reach the clamp and saturation
            case ($urandom_range(3))
               0:       start = 16'($urandom_range(0, 40));
               1:       start = 16'(65535 - $urandom_range(0, 40));
               default: start = 16'($urandom);
            endcase
            drive_request(OP_START, 1'($urandom_range(1)), start, stamp);
            sent++;
            n_ticks = $urandom_range(1, 16);
            repeat (n_ticks) begin
               pick = $urandom_range(9);
               if (pick < 3 && interval != 16'd0) begin
                  delta = $urandom_range(0, 32'(interval) - 32'd1);
               end else if (pick == 8) begin
                  delta = $urandom;
               end else if (pick == 9) begin
                  delta = 32'(interval);
               end else begin
                  delta = 32'(interval) + $urandom_range(0, 3);
               end
               stamp = stamp + delta;
               drive_request(OP_TICK, 1'($urandom_range(1)), 16'($urandom), stamp);
               sent++;
            end
            if ($urandom_range(3) != 0) begin
               drive_request(OP_STOP, 1'($urandom_range(1)), 16'($urandom), $urandom);
               sent++;
            end
         end else begin
            drive_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                          16'($urandom), $urandom);
            sent++;
         end
         if ($urandom_range(29) == 0) begin
            pause_until_drained();
         end
      end
   endtask

   // several register settings, extremes included, each run with one of four idling mixes
   task automatic test_random_settings();
      cfg_type c;
      int      s;
      for (s = 0; s < 8; s++) begin
         case (s)
            0: begin
               c = '{16'd100, 16'd1, 16'd5, 16'd10, 8'd10, 8'd10};
            end
            1: begin
               c.repeat_interval    = 16'($urandom_range(0, 20));
               c.small_step         = 16'($urandom_range(0, 50));
               c.medium_step        = 16'($urandom_range(0, 50));
               c.large_step         = 16'($urandom_range(0, 50));
               c.small_phase_count  = 8'($urandom_range(1, 4));
               c.medium_phase_count = 8'($urandom_range(1, 4));
            end
            2: begin
               c = '{16'd0, VALUE_MAX, VALUE_MAX, VALUE_MAX, 8'd1, 8'd1};
            end
            3: begin
               // zero counts: first phase is never left
               c = '{VALUE_MAX, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0};
            end
            4: begin
               c.repeat_interval    = 16'd0;
               c.small_step         = 16'($urandom_range(1, 9));
               c.medium_step        = 16'($urandom);
               c.large_step         = 16'($urandom);
               c.small_phase_count  = 8'd255;
               c.medium_phase_count = 8'd255;
            end
            5: begin
               c.repeat_interval    = 16'($urandom_range(0, 400));
               c.small_step         = 16'($urandom);
               c.medium_step        = 16'($urandom);
               c.large_step         = 16'($urandom);
               c.small_phase_count  = 8'($urandom);
               c.medium_phase_count = 8'($urandom);
            end
            6: begin
               // medium phase is never left
               c.repeat_interval    = 16'($urandom_range(0, 300));
               c.small_step         = 16'($urandom_range(0, 20));
               c.medium_step        = 16'($urandom_range(0, 100));
               c.large_step         = 16'($urandom_range(0, 1000));
               c.small_phase_count  = 8'($urandom_range(1, 3));
               c.medium_phase_count = 8'd0;
            end
            default: begin
               c.repeat_interval    = 16'($urandom_range(0, 50));
               c.small_step         = 16'($urandom_range(0, 3000));
               c.medium_step        = 16'($urandom_range(0, 9000));
               c.large_step         = 16'($urandom_range(0, 30000));
               c.small_phase_count  = 8'($urandom_range(1, 5));
               c.medium_phase_count = 8'($urandom_range(1, 5));
            end
         endcase
         pause_until_drained();
         apply_settings(c);
         case (s % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 54;
            end
            default: begin
               send_idle_pct = 14;
               rsp_stall_pct = 14;
            end
         endcase
         run_hold_traffic(66);
      end
   endtask

   initial begin
      // register values after reset
      adj_cfg       = '{16'd100, 16'd1, 16'd5, 16'd10, 8'd10, 8'd10};
      adj_held      = 1'b0;
      adj_up        = 1'b0;
      adj_phase     = PHASE_SMALL;
      adj_count     = 8'd0;
      adj_last_time = 32'd0;
      adj_value     = 16'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_hold_repeat();
      test_wrap_and_limits();
      test_phase_rounding();
      test_random_settings();
      pause_until_drained();
      // wait for any stray result
      repeat (8) @(posedge clock);
      if (awaited_adjustments.size() != 0) begin
         $error("%0d results never arrived", awaited_adjustments.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### filelist.f
sv/hrsa_pkg.sv
sv/hrsa_cfg_regs.sv
sv/hrsa_step_core.sv
sv/hold_repeat_step_accelerator.sv
tb/sv/hold_repeat_step_accelerator_test.sv
